// ===== design/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Word formats, command codes and status codes shared by the queue design.
// ----------------------------------------------------------------------------
package dq_pkg;

   // Command codes carried in the cmd field of a request word.
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
   localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;
   localparam logic [2:0] CMD_FIND       = 3'd6;
   localparam logic [2:0] CMD_CLEAR      = 3'd7;

   // Status codes returned in every response word.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_EMPTY     = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data;
      logic [7:0]         position;
      logic [8:0]         occupancy;
   } rsp_type;

endpackage

// ===== design/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque of signed 32-bit words kept in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// Each request word carries a command and a value; every command returns
// exactly one response word with a status, a data word, a find position and
// the number of entries left after the command. Both channels use valid and
// stall; a word moves on a rising edge with valid high and stall low.
// Pushes, clear and every failing push, pop or peek are answered from the
// accept cycle, so the response is valid in the cycle after acceptance.
// Pops and peeks read the memory, whose read data is registered, and respond
// from ST_READ with that data. Find streams one entry per cycle out of the
// memory from the front; a match responds once its compare hits, a miss once
// the last entry has been compared and a find on an empty queue without a read.
// One command is in flight at a time and the next request is taken as soon
// as the previous response sits in the output register, so unstalled pushes
// and clears go back to back while pops and peeks also wait in ST_READ.
// A stalled response holds the output register, and while it is held no new
// request is accepted. Reset empties the queue at once (head and count go
// to zero); the memory contents are left as they are and are never read
// before being rewritten.
// ----------------------------------------------------------------------------
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   // Pointer width addresses the ring; count width holds 0..DEPTH.
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [PW:0]   DEPTH_SUM = (PW + 1)'(DEPTH);
   localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FIND
   } state_type;

   // Ring address of the entry that lies off places behind the front.
   function automatic logic [PW-1:0] ring_at(input logic [PW-1:0] base,
                                             input logic [CW-1:0] off);
      logic [PW:0] sum;
      sum = {1'b0, base} + (PW + 1)'(off);
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[PW-1:0];
   endfunction

   // Control and payload registers.
   state_type          state_ff, state_in;
   logic [PW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] value_ff, value_in;
   logic [CW-1:0]      issue_off_ff, issue_off_in;
   logic [CW-1:0]      cmp_off_ff, cmp_off_in;
   logic               cmp_pending_ff, cmp_pending_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // Memory port signals.
   logic [31:0]        store_mem [DEPTH];
   logic [31:0]        mem_rdata_ff;
   logic               mem_we;
   logic [PW-1:0]      mem_waddr;
   logic [31:0]        mem_wdata;
   logic [PW-1:0]      mem_raddr;

   logic               accept;
   logic               is_full;
   logic               is_empty;
   logic [PW-1:0]      head_prev;
   logic [PW-1:0]      head_next;

   // The output register must be free, or draining this cycle, before a new
   // command is taken, since every command produces its response into it.
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign is_full   = (count_ff == DEPTH_CNT);
   assign is_empty  = (count_ff == '0);
   assign head_prev = (head_ff == '0) ? LAST_PTR : head_ff - 1'b1;
   assign head_next = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      value_in       = value_ff;
      issue_off_in   = issue_off_ff;
      cmp_off_in     = cmp_off_ff;
      cmp_pending_in = cmp_pending_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      mem_we         = 1'b0;
      mem_waddr      = head_prev;
      mem_wdata      = req_word.value;
      mem_raddr      = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = req_word.value;
               // Default response: ok with the current count; arms override.
               rsp_valid_in = 1'b1;
               rsp_in = '{status: STAT_OK, data: '0, position: '0,
                          occupancy: 9'(count_ff)};
               case (req_word.cmd)
                  CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        mem_we           = 1'b1;
                        mem_waddr        = head_prev;
                        head_in          = head_prev;
                        count_in         = count_ff + 1'b1;
                        rsp_in.occupancy = 9'(count_in);
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        mem_we           = 1'b1;
                        mem_waddr        = ring_at(head_ff, count_ff);
                        count_in         = count_ff + 1'b1;
                        rsp_in.occupancy = 9'(count_in);
                     end
                  end
                  CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                     if (is_empty) begin
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        // Data arrives next cycle; the response waits for it.
                        rsp_valid_in = 1'b0;
                        mem_raddr    = head_ff;
                        state_in     = ST_READ;
                        if (req_word.cmd == CMD_POP_FRONT) begin
                           head_in  = head_next;
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  CMD_POP_BACK, CMD_PEEK_BACK: begin
                     if (is_empty) begin
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        mem_raddr    = ring_at(head_ff, count_ff - 1'b1);
                        state_in     = ST_READ;
                        if (req_word.cmd == CMD_POP_BACK) begin
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  CMD_FIND: begin
                     rsp_valid_in   = 1'b0;
                     issue_off_in   = '0;
                     cmp_pending_in = 1'b0;
                     state_in       = ST_FIND;
                  end
                  default: begin
                     // Clear: the ring restarts at address zero.
                     head_in          = '0;
                     count_in         = '0;
                     rsp_in.occupancy = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            // Count was already updated at acceptance for a pop.
            rsp_valid_in = 1'b1;
            rsp_in = '{status: STAT_OK, data: mem_rdata_ff, position: '0,
                       occupancy: 9'(count_ff)};
            state_in = ST_IDLE;
         end
         ST_FIND: begin
            // One read is issued per cycle while the previous one is compared.
            mem_raddr = ring_at(head_ff, issue_off_ff);
            if (cmp_pending_ff && (mem_rdata_ff == value_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: STAT_OK, data: '0, position: 8'(cmp_off_ff),
                          occupancy: 9'(count_ff)};
               cmp_pending_in = 1'b0;
               state_in       = ST_IDLE;
            end else if (issue_off_ff != count_ff) begin
               cmp_pending_in = 1'b1;
               cmp_off_in     = issue_off_ff;
               issue_off_in   = issue_off_ff + 1'b1;
            end else if (cmp_pending_ff) begin
               // Last entry missed; the walk ends on the next cycle.
               cmp_pending_in = 1'b0;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: STAT_NOT_FOUND, data: '0, position: '0,
                          occupancy: 9'(count_ff)};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Entry storage. Writes happen only on the acceptance cycle of a push and
   // reads only for later commands, so a read never meets a write in flight.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= store_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      issue_off_ff <= issue_off_in;
      cmp_off_ff   <= cmp_off_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         count_ff       <= '0;
         cmp_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         cmp_pending_ff <= cmp_pending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

endmodule
